// ===== sv/ptc_pkg.sv =====
// ============================================================================
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Word formats, coefficient bundle, register map and arithmetic constants.
// ============================================================================
package ptc_pkg;

    localparam int TEMP_REF    = 128000;
    localparam int PRESS_SCALE = 3125;
    localparam int P_FULL      = 1048576;
    localparam int DIV_STEPS   = 64;
    localparam int ADDR_W      = 5;

    typedef enum logic [2:0] {
        REG_TEMP_OFFSET = 3'd0,
        REG_TEMP_GAIN   = 3'd1,
        REG_PRESS_SCALE = 3'd2,
        REG_PRESS_23    = 3'd3,
        REG_PRESS_45    = 3'd4,
        REG_PRESS_67    = 3'd5,
        REG_PRESS_89    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic        [31:0] pressure_q24_8;
        logic               divide_fault;
    } out_word_t;

    typedef struct packed {
        logic        [15:0] c1;
        logic signed [15:0] c2;
        logic signed [15:0] c3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coef_t;

    typedef struct packed {
        logic signed [31:0] tcent;
        logic signed [31:0] fine;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [19:0] raw_pressure;
    } temp_word_t;

    typedef struct packed {
        side_t              side;
        logic        [63:0] num;
        logic signed [30:0] den;
    } frac_word_t;

    typedef struct packed {
        side_t       side;
        logic [63:0] quo;
        logic        fault;
    } quo_word_t;

endpackage

// ===== sv/pressure_temperature_compensation.sv =====
// Throughput: one word per cycle while the result word is not held; the pipelined divider keeps the pipe full.
// A stalled result word holds the whole pipeline, input stall follows it.
// Reset clears all valid bits and zeroes the coefficient registers.
// ============================================================================
// pressure_temperature_compensation: barometric integer compensation
// Register file, temperature stages, polynomial, divider and correction.
// ============================================================================
module pressure_temperature_compensation (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  ptc_pkg::in_word_t                  sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output ptc_pkg::out_word_t                 result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptc_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [15:0]         temp_offset_reg;
    logic [31:0]         temp_gain_reg;
    logic [15:0]         press_scale_reg;
    logic [31:0]         press_23_reg, press_45_reg, press_67_reg, press_89_reg;
    logic                wr;
    ptc_pkg::reg_idx_t   idx;
    ptc_pkg::coef_t      coef;
    logic                en;
    logic                t_valid, c_valid, d_valid;
    ptc_pkg::temp_word_t t_word;
    ptc_pkg::frac_word_t c_word;
    ptc_pkg::quo_word_t  d_word;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = ptc_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_offset_reg <= '0;
            temp_gain_reg   <= '0;
            press_scale_reg <= '0;
            press_23_reg    <= '0;
            press_45_reg    <= '0;
            press_67_reg    <= '0;
            press_89_reg    <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                ptc_pkg::REG_TEMP_OFFSET: temp_offset_reg <= pwdata[15:0];
                ptc_pkg::REG_TEMP_GAIN:   temp_gain_reg   <= pwdata;
                ptc_pkg::REG_PRESS_SCALE: press_scale_reg <= pwdata[15:0];
                ptc_pkg::REG_PRESS_23:    press_23_reg    <= pwdata;
                ptc_pkg::REG_PRESS_45:    press_45_reg    <= pwdata;
                ptc_pkg::REG_PRESS_67:    press_67_reg    <= pwdata;
                ptc_pkg::REG_PRESS_89:    press_89_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ptc_pkg::REG_TEMP_OFFSET: prdata = {16'h0, temp_offset_reg};
            ptc_pkg::REG_TEMP_GAIN:   prdata = temp_gain_reg;
            ptc_pkg::REG_PRESS_SCALE: prdata = {16'h0, press_scale_reg};
            ptc_pkg::REG_PRESS_23:    prdata = press_23_reg;
            ptc_pkg::REG_PRESS_45:    prdata = press_45_reg;
            ptc_pkg::REG_PRESS_67:    prdata = press_67_reg;
            ptc_pkg::REG_PRESS_89:    prdata = press_89_reg;
            default:                  prdata = 32'h0;
        endcase
    end

    assign coef.c1 = temp_offset_reg;
    assign coef.c2 = temp_gain_reg[15:0];
    assign coef.c3 = temp_gain_reg[31:16];
    assign coef.p1 = press_scale_reg;
    assign coef.p2 = press_23_reg[15:0];
    assign coef.p3 = press_23_reg[31:16];
    assign coef.p4 = press_45_reg[15:0];
    assign coef.p5 = press_45_reg[31:16];
    assign coef.p6 = press_67_reg[15:0];
    assign coef.p7 = press_67_reg[31:16];
    assign coef.p8 = press_89_reg[15:0];
    assign coef.p9 = press_89_reg[31:16];

    // whole pipe advances unless the result word is held
    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;

    ptc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample_valid),
        .din       (sample),
        .coef      (coef),
        .out_valid (t_valid),
        .dout      (t_word)
    );

    ptc_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t_valid),
        .din       (t_word),
        .coef      (coef),
        .out_valid (c_valid),
        .dout      (c_word)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid),
        .din       (c_word),
        .out_valid (d_valid),
        .dout      (d_word)
    );

    ptc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .din       (d_word),
        .coef      (coef),
        .out_valid (result_valid),
        .dout      (result)
    );

`ifndef SYNTH
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.divide_fault |-> result.pressure_q24_8 == 32'h0)
        else $error("fault word carries nonzero pressure");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("input stalled without a held result word");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr && idx == ptc_pkg::REG_TEMP_OFFSET |=> temp_offset_reg == $past(pwdata[15:0]))
        else $error("coefficient write lost");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("held result word dropped");
`endif

endmodule

// ===== sv/ptc_temp.sv =====
// ============================================================================
// ptc_temp: temperature compensation pipeline
// Four stages: products, shifted square times coefficient, fine sum, centi.
// ============================================================================
module ptc_temp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ptc_pkg::in_word_t   din,
    input  ptc_pkg::coef_t      coef,
    output logic                out_valid,
    output ptc_pkg::temp_word_t dout
);

    logic [3:0]         vld_reg;
    logic signed [17:0] diff_a;
    logic signed [16:0] diff_d;
    logic signed [33:0] prod_a_next, prod_a_reg;
    logic signed [33:0] sq_d_next, sq_d_reg;
    logic signed [31:0] sq_wrap;
    logic signed [19:0] sq_sh;
    logic signed [31:0] tv1_next, tv1_reg;
    logic signed [35:0] prod_b_next, prod_b_reg;
    logic signed [31:0] tv2;
    logic signed [31:0] fine_next, fine_reg, fine4_reg;
    logic signed [31:0] tcent_next, tcent_reg;
    logic [19:0]        rp1_reg, rp2_reg, rp3_reg, rp4_reg;

    assign diff_a = $signed({1'b0, din.raw_temperature[19:3]})
                  - $signed({1'b0, coef.c1, 1'b0});
    assign diff_d = $signed({1'b0, din.raw_temperature[19:4]})
                  - $signed({1'b0, coef.c1});
    assign prod_a_next = diff_a * coef.c2;
    assign sq_d_next   = diff_d * diff_d;

    assign tv1_next    = $signed(prod_a_reg[31:0]) >>> 11;
    assign sq_wrap     = $signed(sq_d_reg[31:0]) >>> 12;
    assign sq_sh       = sq_wrap[19:0];
    assign prod_b_next = sq_sh * coef.c3;

    assign tv2       = $signed(prod_b_reg[31:0]) >>> 14;
    assign fine_next = tv1_reg + tv2;

    assign tcent_next = ((fine_reg <<< 2) + fine_reg + 32'sd128) >>> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a_next;
            sq_d_reg   <= sq_d_next;
            rp1_reg    <= din.raw_pressure;
            tv1_reg    <= tv1_next;
            prod_b_reg <= prod_b_next;
            rp2_reg    <= rp1_reg;
            fine_reg   <= fine_next;
            rp3_reg    <= rp2_reg;
            tcent_reg  <= tcent_next;
            fine4_reg  <= fine_reg;
            rp4_reg    <= rp3_reg;
        end
    end

    assign out_valid         = vld_reg[3];
    assign dout.side.tcent   = tcent_reg;
    assign dout.side.fine    = fine4_reg;
    assign dout.raw_pressure = rp4_reg;

endmodule

// ===== sv/ptc_coef.sv =====
// ============================================================================
// ptc_coef: pressure polynomial pipeline
// Eight stages from fine temperature and raw pressure to dividend and divisor.
// ============================================================================
module ptc_coef (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ptc_pkg::temp_word_t din,
    input  ptc_pkg::coef_t      coef,
    output logic                out_valid,
    output ptc_pkg::frac_word_t dout
);

    logic [7:0]             vld_reg;
    ptc_pkg::side_t         side_reg [0:7];
    logic [20:0]            pd_reg   [0:4];

    logic signed [32:0]     v1_next, v1_reg;
    logic signed [65:0]     vv_next, vv_reg;
    logic signed [48:0]     vp5_next, vp5_reg, vp5b_reg;
    logic signed [48:0]     vp2_next, vp2_reg, vp2b_reg, vp2c_reg;
    logic signed [48:0]     l6_next, l6_reg, l3_next, l3_reg;
    logic signed [47:0]     h6_next, h6_reg, h3_next, h3_reg;
    logic [63:0]            v2a_next, v2a_reg, v2b_next, v2b_reg;
    logic signed [63:0]     t3_next, t3_reg, t3_sh, vp2_sh;
    logic [63:0]            v2_next, v2_reg;
    logic signed [63:0]     x_next, x_reg;
    logic [63:0]            n0_next, n0_reg, y_next, y_reg;
    logic [43:0]            nlo_next, nlo_reg, nhi_next, nhi_reg;
    logic [47:0]            ylo_next, ylo_reg, yhi_next, yhi_reg;
    logic [63:0]            num_next, num_reg, z_next;
    logic signed [30:0]     den_reg;

    // stage 1: offset fine temperature, pressure complement
    assign v1_next = $signed({din.side.fine[31], din.side.fine})
                   - 33'(ptc_pkg::TEMP_REF);

    // stage 2: square and linear terms
    assign vv_next  = v1_reg * v1_reg;
    assign vp5_next = v1_reg * coef.p5;
    assign vp2_next = v1_reg * coef.p2;

    // stage 3: square split in halves times coefficients
    assign l6_next = $signed({1'b0, vv_reg[31:0]}) * coef.p6;
    assign h6_next = $signed(vv_reg[63:32]) * coef.p6;
    assign l3_next = $signed({1'b0, vv_reg[31:0]}) * coef.p3;
    assign h3_next = $signed(vv_reg[63:32]) * coef.p3;

    // stage 4: recombine halves
    assign v2a_next = {{15{l6_reg[48]}}, l6_reg} + {h6_reg[31:0], 32'h0};
    assign v2b_next = {vp5b_reg[46:0], 17'h0}
                    + {{13{coef.p4[15]}}, coef.p4, 35'h0};
    assign t3_next  = {{15{l3_reg[48]}}, l3_reg} + {h3_reg[31:0], 32'h0};

    // stage 5
    assign t3_sh   = t3_reg >>> 8;
    assign vp2_sh  = {{3{vp2c_reg[48]}}, vp2c_reg, 12'h0};
    assign v2_next = v2a_reg + v2b_reg;
    assign x_next  = t3_sh + vp2_sh;

    // stage 6
    assign n0_next = {12'h0, pd_reg[4], 31'h0} - v2_reg;
    assign y_next  = x_reg + 64'h0000_8000_0000_0000;

    // stage 7: 64-bit products cut into halves
    assign nlo_next = n0_reg[31:0] * 12'(ptc_pkg::PRESS_SCALE);
    assign nhi_next = n0_reg[63:32] * 12'(ptc_pkg::PRESS_SCALE);
    assign ylo_next = y_reg[31:0] * coef.p1;
    assign yhi_next = y_reg[63:32] * coef.p1;

    // stage 8
    assign num_next = {20'h0, nlo_reg} + {nhi_reg[31:0], 32'h0};
    assign z_next   = {16'h0, ylo_reg} + {yhi_reg[31:0], 32'h0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= din.side;
            for (int i = 1; i < 8; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            pd_reg[0] <= 21'(ptc_pkg::P_FULL) - {1'b0, din.raw_pressure};
            for (int i = 1; i < 5; i++)
            begin
                pd_reg[i] <= pd_reg[i-1];
            end
            v1_reg   <= v1_next;
            vv_reg   <= vv_next;
            vp5_reg  <= vp5_next;
            vp2_reg  <= vp2_next;
            l6_reg   <= l6_next;
            h6_reg   <= h6_next;
            l3_reg   <= l3_next;
            h3_reg   <= h3_next;
            vp5b_reg <= vp5_reg;
            vp2b_reg <= vp2_reg;
            v2a_reg  <= v2a_next;
            v2b_reg  <= v2b_next;
            t3_reg   <= t3_next;
            vp2c_reg <= vp2b_reg;
            v2_reg   <= v2_next;
            x_reg    <= x_next;
            n0_reg   <= n0_next;
            y_reg    <= y_next;
            nlo_reg  <= nlo_next;
            nhi_reg  <= nhi_next;
            ylo_reg  <= ylo_next;
            yhi_reg  <= yhi_next;
            num_reg  <= num_next;
            den_reg  <= $signed(z_next[63:33]);
        end
    end

    assign out_valid = vld_reg[7];
    assign dout.side = side_reg[7];
    assign dout.num  = num_reg;
    assign dout.den  = den_reg;

endmodule

// ===== sv/ptc_div.sv =====
// ============================================================================
// ptc_div: pipelined signed 64-bit divider, one quotient bit per stage
// Sign strip, 64 restoring steps, sign restore; quotient truncates to zero.
// ============================================================================
module ptc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  ptc_pkg::frac_word_t din,
    output logic                out_valid,
    output ptc_pkg::quo_word_t  dout
);

    localparam int N = ptc_pkg::DIV_STEPS;

    logic [N+1:0]   vld_reg;
    logic [63:0]    n_reg    [0:N];
    logic [30:0]    rem_reg  [0:N];
    logic [30:0]    md_reg   [0:N];
    logic           neg_reg  [0:N];
    logic           fault_reg[0:N];
    ptc_pkg::side_t side_reg [0:N];
    logic [63:0]    quo_reg;
    logic           quo_fault_reg;
    ptc_pkg::side_t quo_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N:0], in_valid};
        end
    end

    // sign strip
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]     <= din.num[63] ? (64'h0 - din.num) : din.num;
            md_reg[0]    <= din.den[30] ? (31'h0 - din.den) : din.den;
            rem_reg[0]   <= '0;
            neg_reg[0]   <= din.num[63] ^ din.den[30];
            fault_reg[0] <= (din.den == 31'sd0);
            side_reg[0]  <= din.side;
        end
    end

    for (genvar i = 1; i <= N; i++)
    begin : g_step
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        assign trial = {rem_reg[i-1], n_reg[i-1][63]};
        assign ge    = trial >= {1'b0, md_reg[i-1]};
        assign diff  = trial - {1'b0, md_reg[i-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]   <= ge ? diff[30:0] : trial[30:0];
                n_reg[i]     <= {n_reg[i-1][62:0], ge};
                md_reg[i]    <= md_reg[i-1];
                neg_reg[i]   <= neg_reg[i-1];
                fault_reg[i] <= fault_reg[i-1];
                side_reg[i]  <= side_reg[i-1];
            end
        end
    end

    // sign restore
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg       <= neg_reg[N] ? (64'h0 - n_reg[N]) : n_reg[N];
            quo_fault_reg <= fault_reg[N];
            quo_side_reg  <= side_reg[N];
        end
    end

    assign out_valid  = vld_reg[N+1];
    assign dout.quo   = quo_reg;
    assign dout.fault = quo_fault_reg;
    assign dout.side  = quo_side_reg;

endmodule

// ===== sv/ptc_post.sv =====
// ============================================================================
// ptc_post: quotient correction pipeline and result register
// Six stages: quadratic and linear corrections, sum, Q24.8 offset, fault mask.
// ============================================================================
module ptc_post (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ptc_pkg::quo_word_t din,
    input  ptc_pkg::coef_t     coef,
    output logic               out_valid,
    output ptc_pkg::out_word_t dout
);

    logic [5:0]         vld_reg;
    ptc_pkg::side_t     side_reg  [0:4];
    logic               fault_reg [0:4];
    logic [63:0]        q_reg     [0:2];

    logic signed [63:0] q13;
    logic [63:0]        ll_next, ll_reg;
    logic [31:0]        lh_next, lh_reg;
    logic signed [48:0] ql8_next, ql8_reg;
    logic [31:0]        qh8_next, qh8_reg;
    logic [63:0]        s_next, s_reg;
    logic signed [63:0] w2;
    logic signed [63:0] v2_next, v2_reg, v2b_reg;
    logic signed [48:0] s9l_next, s9l_reg;
    logic [31:0]        s9h_next, s9h_reg;
    logic signed [63:0] t9;
    logic [63:0]        v1_next, v1_reg, qv2_next, qv2_reg, u_next, u_reg;
    logic [31:0]        press;
    ptc_pkg::out_word_t res_reg;

    // stage 1: square of quotient and linear product, by halves
    assign q13      = $signed(din.quo) >>> 13;
    assign ll_next  = q13[31:0] * q13[31:0];
    assign lh_next  = q13[31:0] * q13[63:32];
    assign ql8_next = $signed({1'b0, din.quo[31:0]}) * coef.p8;
    assign qh8_next = din.quo[63:32] * {{16{coef.p8[15]}}, coef.p8};

    // stage 2: cross term counted twice
    assign s_next  = ll_reg + {lh_reg[30:0], 33'h0};
    assign w2      = {{15{ql8_reg[48]}}, ql8_reg} + {qh8_reg, 32'h0};
    assign v2_next = w2 >>> 19;

    // stage 3
    assign s9l_next = $signed({1'b0, s_reg[31:0]}) * coef.p9;
    assign s9h_next = s_reg[63:32] * {{16{coef.p9[15]}}, coef.p9};

    // stage 4
    assign t9       = {{15{s9l_reg[48]}}, s9l_reg} + {s9h_reg, 32'h0};
    assign v1_next  = t9 >>> 25;
    assign qv2_next = q_reg[2] + v2b_reg;

    // stage 5
    assign u_next = qv2_reg + v1_reg;

    // stage 6: only the low word of the shifted sum is kept
    assign press = u_reg[39:8] + {{12{coef.p7[15]}}, coef.p7, 4'h0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0]  <= din.side;
            fault_reg[0] <= din.fault;
            q_reg[0]     <= din.quo;
            for (int i = 1; i < 5; i++)
            begin
                side_reg[i]  <= side_reg[i-1];
                fault_reg[i] <= fault_reg[i-1];
            end
            for (int i = 1; i < 3; i++)
            begin
                q_reg[i] <= q_reg[i-1];
            end
            ll_reg  <= ll_next;
            lh_reg  <= lh_next;
            ql8_reg <= ql8_next;
            qh8_reg <= qh8_next;
            s_reg   <= s_next;
            v2_reg  <= v2_next;
            v2b_reg <= v2_reg;
            s9l_reg <= s9l_next;
            s9h_reg <= s9h_next;
            v1_reg  <= v1_next;
            qv2_reg <= qv2_next;
            u_reg   <= u_next;
            res_reg.temperature_centi <= side_reg[4].tcent;
            res_reg.fine_temperature  <= side_reg[4].fine;
            res_reg.pressure_q24_8    <= fault_reg[4] ? 32'h0 : press;
            res_reg.divide_fault      <= fault_reg[4];
        end
    end

    assign out_valid = vld_reg[5];
    assign dout      = res_reg;

endmodule
